// ===== design/lcaq_pkg.sv =====
// ---------------------------------------------------------------------------
// lcaq_pkg
// Shared types, constants and label bit functions for the lca query engine.
// ---------------------------------------------------------------------------
package lcaq_pkg;

    localparam int NODE_W      = 10;
    localparam int PAR_W       = 11;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_AW     = 3;

    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // strip entry decision for one node
    typedef struct packed {
        logic  direct;
        t_node idx;
    } t_enter;

    function automatic t_node neg_lbl(t_node v);
        return ~v + t_node'(1);
    endfunction

    function automatic t_node low_bit(t_node v);
        return v & neg_lbl(v);
    endfunction

    // each bit decided on its own: set only if nothing above it is set
    function automatic t_node high_bit(t_node v);
        t_node r;
        r = '0;
        for (int b = 0; b < NODE_W; b++) begin
            r[b] = v[b] && ((v >> (b + 1)) == t_node'(0));
        end
        return r;
    endfunction

endpackage

// ===== design/tree_lca_query_engine_core.sv =====
// ---------------------------------------------------------------------------
// tree_lca_query_engine_core
// Pipelined lowest-common-ancestor query engine over five per-node tables.
// ---------------------------------------------------------------------------
// usage:
//   slave stream carries requests; tuser[0] is the opcode (0 load, 1 query).
//   a load writes parent, preorder, inlabel, ascendant and head entries at
//   node_x and returns nothing; a query returns the lca of node_x, node_y
//   on the master stream. tables must be loaded before they are queried.
// pipeline and throughput:
//   one request per cycle while credit remains. a query passes through the
//   stages inlabel/ascendant read and hz, strip entry and head read,
//   parent read, preorder read, and preorder compare, in that order.
//   results queue in an 8-entry output fifo; a credit count of queries in
//   flight plus queued keeps the pipeline free-running, so tready drops only
//   once 8 query results are outstanding.
// reset:
//   synchronous active-low; clears stage valid bits, fifo pointers and the
//   credit count. table contents are not cleared (undefined until loaded).
// receiver stall:
//   results wait in the fifo; requests keep flowing until credit runs out.
// ---------------------------------------------------------------------------
module tree_lca_query_engine_core
    import lcaq_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // node_x[9:0], node_y[19:10], entry_parent[30:20], entry_preorder[40:31],
    // entry_inlabel[50:41], entry_ascendant[60:51], entry_head[70:61]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  logic [0:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // ancestor[9:0]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // ---------------- request unpack ----------------
    logic             w_acc;
    t_opcode          w_op;
    t_node            w_x;
    t_node            w_y;
    logic [PAR_W-1:0] w_par;
    t_node            w_pre;
    t_node            w_lab;
    t_node            w_asc;
    t_node            w_head;
    logic             w_load_in;

    assign w_op   = t_opcode'(i_s_axis_tuser[0]);
    assign w_x    = i_s_axis_tdata[9:0];
    assign w_y    = i_s_axis_tdata[19:10];
    assign w_par  = i_s_axis_tdata[30:20];
    assign w_pre  = i_s_axis_tdata[40:31];
    assign w_lab  = i_s_axis_tdata[50:41];
    assign w_asc  = i_s_axis_tdata[60:51];
    assign w_head = i_s_axis_tdata[70:61];

    assign w_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load_in = w_acc && (w_op == OP_LOAD);

    // ---------------- stage a: inlabel and ascendant read ----------------
    logic             r_a_valid;
    t_opcode          r_a_op;
    t_node            r_a_x;
    t_node            r_a_y;
    logic [PAR_W-1:0] r_a_par;
    t_node            r_a_pre;
    t_node            r_a_head;
    t_node            w_lx;
    t_node            w_ly;
    t_node            w_asx;
    t_node            w_asy;
    t_node            w_hb;
    t_node            w_hz;

    lcaq_tbl #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_inlabel (
        .i_clk     (i_clk),
        .i_we      (w_load_in),
        .i_waddr   (w_x),
        .i_wdata   (w_lab),
        .i_raddr_a (w_x),
        .i_raddr_b (w_y),
        .o_rdata_a (w_lx),
        .o_rdata_b (w_ly)
    );

    lcaq_tbl #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_ascendant (
        .i_clk     (i_clk),
        .i_we      (w_load_in),
        .i_waddr   (w_x),
        .i_wdata   (w_asc),
        .i_raddr_a (w_x),
        .i_raddr_b (w_y),
        .o_rdata_a (w_asx),
        .o_rdata_b (w_asy)
    );

    // highest differing inlabel bit, lowest one if the labels match
    assign w_hb = (w_lx == w_ly) ? low_bit(w_lx) : high_bit(w_lx ^ w_ly);
    // lowest common ascendant bit at or above it
    assign w_hz = low_bit(w_asx & w_asy & neg_lbl(w_hb));

    // ---------------- stage b: strip entry index, head read ----------------
    logic             r_b_valid;
    t_opcode          r_b_op;
    t_node            r_b_x;
    t_node            r_b_y;
    logic [PAR_W-1:0] r_b_par;
    t_node            r_b_pre;
    t_node            r_b_head;
    t_node            r_b_hz;
    t_node            r_b_lx;
    t_node            r_b_ly;
    t_node            r_b_asx;
    t_node            r_b_asy;
    t_enter           w_ent_x;
    t_enter           w_ent_y;
    t_node            w_top_x;
    t_node            w_top_y;

    lcaq_enter u_enter_x (
        .i_lab   (r_b_lx),
        .i_asc   (r_b_asx),
        .i_hz    (r_b_hz),
        .o_enter (w_ent_x)
    );

    lcaq_enter u_enter_y (
        .i_lab   (r_b_ly),
        .i_asc   (r_b_asy),
        .i_hz    (r_b_hz),
        .o_enter (w_ent_y)
    );

    lcaq_tbl #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_head (
        .i_clk     (i_clk),
        .i_we      (r_b_valid && (r_b_op == OP_LOAD)),
        .i_waddr   (r_b_x),
        .i_wdata   (r_b_head),
        .i_raddr_a (w_ent_x.idx),
        .i_raddr_b (w_ent_y.idx),
        .o_rdata_a (w_top_x),
        .o_rdata_b (w_top_y)
    );

    // ---------------- stage c: parent read of the strip head ----------------
    logic             r_c_valid;
    t_opcode          r_c_op;
    t_node            r_c_x;
    t_node            r_c_y;
    logic [PAR_W-1:0] r_c_par;
    t_node            r_c_pre;
    logic             r_c_dir_x;
    logic             r_c_dir_y;
    logic [PAR_W-1:0] w_px;
    logic [PAR_W-1:0] w_py;

    lcaq_tbl #(.WIDTH(PAR_W), .DEPTH(NODE_COUNT)) u_parent (
        .i_clk     (i_clk),
        .i_we      (r_c_valid && (r_c_op == OP_LOAD)),
        .i_waddr   (r_c_x),
        .i_wdata   (r_c_par),
        .i_raddr_a (w_top_x),
        .i_raddr_b (w_top_y),
        .o_rdata_a (w_px),
        .o_rdata_b (w_py)
    );

    // ---------------- stage d: entered nodes, preorder read ----------------
    logic             r_d_valid;
    t_opcode          r_d_op;
    t_node            r_d_x;
    t_node            r_d_y;
    t_node            r_d_pre;
    logic             r_d_dir_x;
    logic             r_d_dir_y;
    t_node            r_d_top_x;
    t_node            r_d_top_y;
    t_node            w_ex;
    t_node            w_ey;
    t_node            w_prex;
    t_node            w_prey;

    // a negative parent marks a root: the strip head itself is entered
    assign w_ex = r_d_dir_x ? r_d_x : (w_px[PAR_W-1] ? r_d_top_x : w_px[NODE_W-1:0]);
    assign w_ey = r_d_dir_y ? r_d_y : (w_py[PAR_W-1] ? r_d_top_y : w_py[NODE_W-1:0]);

    lcaq_tbl #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_preorder (
        .i_clk     (i_clk),
        .i_we      (r_d_valid && (r_d_op == OP_LOAD)),
        .i_waddr   (r_d_x),
        .i_wdata   (r_d_pre),
        .i_raddr_a (w_ex),
        .i_raddr_b (w_ey),
        .o_rdata_a (w_prex),
        .o_rdata_b (w_prey)
    );

    // ---------------- stage e: preorder compare ----------------
    logic             r_e_valid;
    t_opcode          r_e_op;
    t_node            r_e_ex;
    t_node            r_e_ey;
    t_node            w_anc;
    logic             w_push;

    assign w_anc  = (w_prex < w_prey) ? r_e_ex : r_e_ey;
    assign w_push = r_e_valid && (r_e_op == OP_QUERY);

    // ---------------- stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_a_valid <= w_acc;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // payload moves every cycle; valid bits mark live requests
    always_ff @(posedge i_clk) begin
        r_a_op    <= w_op;
        r_a_x     <= w_x;
        r_a_y     <= w_y;
        r_a_par   <= w_par;
        r_a_pre   <= w_pre;
        r_a_head  <= w_head;

        r_b_op    <= r_a_op;
        r_b_x     <= r_a_x;
        r_b_y     <= r_a_y;
        r_b_par   <= r_a_par;
        r_b_pre   <= r_a_pre;
        r_b_head  <= r_a_head;
        r_b_hz    <= w_hz;
        r_b_lx    <= w_lx;
        r_b_ly    <= w_ly;
        r_b_asx   <= w_asx;
        r_b_asy   <= w_asy;

        r_c_op    <= r_b_op;
        r_c_x     <= r_b_x;
        r_c_y     <= r_b_y;
        r_c_par   <= r_b_par;
        r_c_pre   <= r_b_pre;
        r_c_dir_x <= w_ent_x.direct;
        r_c_dir_y <= w_ent_y.direct;

        r_d_op    <= r_c_op;
        r_d_x     <= r_c_x;
        r_d_y     <= r_c_y;
        r_d_pre   <= r_c_pre;
        r_d_dir_x <= r_c_dir_x;
        r_d_dir_y <= r_c_dir_y;
        r_d_top_x <= w_top_x;
        r_d_top_y <= w_top_y;

        r_e_op    <= r_d_op;
        r_e_ex    <= w_ex;
        r_e_ey    <= w_ey;
    end

    // ---------------- output queue and credit ----------------
    logic [OUTQ_AW:0] r_credit;
    logic [OUTQ_AW:0] n_credit;
    logic             w_out_acc;
    logic             w_credit_inc;
    t_node            w_q_data;

    lcaq_fifo u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_anc),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_q_data)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-NODE_W){1'b0}}, w_q_data};
    assign w_out_acc      = o_m_axis_tvalid && i_m_axis_tready;
    assign w_credit_inc   = w_acc && (w_op == OP_QUERY);

    // queries in flight plus queued results never exceed the fifo depth
    assign o_s_axis_tready = (r_credit < (OUTQ_AW+1)'(OUTQ_DEPTH));

    always_comb begin
        n_credit = r_credit + (OUTQ_AW+1)'(w_credit_inc) - (OUTQ_AW+1)'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (OUTQ_AW+1)'(OUTQ_DEPTH))
        else $error("credit count above fifo depth");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_credit != '0))
        else $error("result queued without outstanding credit");

    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_op == OP_QUERY)) |-> ##5 w_push)
        else $error("query result not pushed after pipeline latency");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_in |-> ##5 !w_push)
        else $error("load request produced a result");
`endif

endmodule

// ===== design/lcaq_tbl.sv =====
// ---------------------------------------------------------------------------
// lcaq_tbl
// Per-node table: one write port, two registered read ports, zero beyond range.
// ---------------------------------------------------------------------------
module lcaq_tbl
    import lcaq_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  t_node            i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  t_node            i_raddr_a,
    input  t_node            i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;
    logic             r_ok_a;
    logic             r_ok_b;
    logic             w_wr_ok;
    logic             w_ok_a;
    logic             w_ok_b;

    assign w_wr_ok = 32'(i_waddr) < DEPTH;
    assign w_ok_a  = 32'(i_raddr_a) < DEPTH;
    assign w_ok_b  = 32'(i_raddr_b) < DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_we && w_wr_ok) begin
            r_mem[AW'(i_waddr)] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[AW'(i_raddr_a)];
        r_rd_b <= r_mem[AW'(i_raddr_b)];
        r_ok_a <= w_ok_a;
        r_ok_b <= w_ok_b;
    end

    // an index beyond the table reads as zero
    assign o_rdata_a = r_ok_a ? r_rd_a : '0;
    assign o_rdata_b = r_ok_b ? r_rd_b : '0;

endmodule

// ===== design/lcaq_enter.sv =====
// ---------------------------------------------------------------------------
// lcaq_enter
// Strip entry decision: node already in strip, or head table index to use.
// ---------------------------------------------------------------------------
module lcaq_enter
    import lcaq_pkg::*;
(
    input  t_node  i_lab,
    input  t_node  i_asc,
    input  t_node  i_hz,
    output t_enter o_enter
);

    t_node w_mask;
    t_node w_jump;

    assign w_mask = i_asc & (i_hz - t_node'(1));
    assign w_jump = high_bit(w_mask);

    assign o_enter.direct = (low_bit(i_lab) == i_hz);
    assign o_enter.idx    = (i_lab & neg_lbl(w_jump)) | w_jump;

endmodule

// ===== design/lcaq_fifo.sv =====
// ---------------------------------------------------------------------------
// lcaq_fifo
// Small result queue between the pipeline and the output stream.
// ---------------------------------------------------------------------------
module lcaq_fifo
    import lcaq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_node i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_node o_data
);

    t_node              r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wr;
    logic [OUTQ_AW-1:0] r_rd;
    logic [OUTQ_AW:0]   r_cnt;
    logic               w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + OUTQ_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + OUTQ_AW'(1);
            end
            r_cnt <= r_cnt + (OUTQ_AW+1)'(i_push) - (OUTQ_AW+1)'(w_pop);
        end
    end

endmodule
